/* design/dnsr_pkg.sv */
// shared constants, types and answer table of the dns redirect responder
`default_nettype none
package dnsr_pkg;

	localparam int MAX_PACKET_BYTES_DEF = 512;
	localparam int HDR_BYTES            = 12;
	localparam int ANSWER_BYTES         = 16;
	localparam int ANS_IDX_W            = $clog2(ANSWER_BYTES);

	// header bytes that get overwritten
	localparam int POS_FLAGS_HI  = 2;
	localparam int POS_FLAGS_LO  = 3;
	localparam int POS_ANCOUNT_HI = 6;
	localparam int POS_ANCOUNT_LO = 7;

	localparam logic [15:0] RESP_FLAGS   = 16'h8180;
	localparam logic [15:0] ANCOUNT_ONE  = 16'h0001;
	localparam logic [15:0] NAME_POINTER = 16'hC00C;
	localparam logic [15:0] RR_TYPE_A    = 16'h0001;
	localparam logic [15:0] RR_CLASS_IN  = 16'h0001;
	localparam logic [31:0] RR_TTL       = 32'd60;
	localparam logic [15:0] RR_RDLENGTH  = 16'd4;

	localparam int          APB_ADDR_W       = 3;
	localparam logic [APB_ADDR_W-1:0] ADDR_REDIRECT_IP = 3'd0;

	// one result of the parser for one accepted byte
	typedef struct packed {
		logic       emit;    // a result group follows
		logic       answer;  // group is the echoed byte plus the 16-byte answer
		logic [7:0] data;
		logic       last;
		logic       abort;
	} dnsr_res_t;

	// byte k of the appended answer record
	function automatic logic [7:0] answer_byte(input logic [ANS_IDX_W-1:0] k,
			input logic [31:0] ip);
		logic [7:0] b;
		b = 8'h00;
		unique case (k)
			4'd0:    b = NAME_POINTER[15:8];
			4'd1:    b = NAME_POINTER[7:0];
			4'd2:    b = RR_TYPE_A[15:8];
			4'd3:    b = RR_TYPE_A[7:0];
			4'd4:    b = RR_CLASS_IN[15:8];
			4'd5:    b = RR_CLASS_IN[7:0];
			4'd6:    b = RR_TTL[31:24];
			4'd7:    b = RR_TTL[23:16];
			4'd8:    b = RR_TTL[15:8];
			4'd9:    b = RR_TTL[7:0];
			4'd10:   b = RR_RDLENGTH[15:8];
			4'd11:   b = RR_RDLENGTH[7:0];
			4'd12:   b = ip[31:24];
			4'd13:   b = ip[23:16];
			4'd14:   b = ip[15:8];
			default: b = ip[7:0];
		endcase
		return b;
	endfunction

endpackage
`default_nettype wire

/* design/dnsr_parser.sv */
// query parser: tracks header, labels and type/class, decides each result
`default_nettype none
module dnsr_parser import dnsr_pkg::*; #(
	parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [7:0] rx_byte,
	input  wire logic       rx_last,
	input  wire logic       consume,
	output dnsr_res_t       res
);

	localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_PACKET_BYTES);

	typedef enum logic [5:0] {
		PH_HEADER  = 6'b000001,
		PH_LABLEN  = 6'b000010,
		PH_LABEL   = 6'b000100,
		PH_TAIL    = 6'b001000,
		PH_SWALLOW = 6'b010000,
		PH_DISCARD = 6'b100000
	} phase_t;

	phase_t           phase_q, phase_d;
	logic [POS_W-1:0] pos_q, pos_d;
	logic [7:0]       lab_q, lab_d;
	logic [1:0]       tail_q, tail_d;
	logic [7:0]       lab_dec;

	always_comb begin
		phase_d = phase_q;
		pos_d   = pos_q;
		lab_d   = lab_q;
		tail_d  = tail_q;
		res     = '{emit: 1'b0, answer: 1'b0, data: rx_byte, last: 1'b0, abort: 1'b0};
		lab_dec = (lab_q != 8'd0) ? lab_q - 8'd1 : lab_q;

		if (phase_q == PH_SWALLOW || phase_q == PH_DISCARD) begin
			if (rx_last) begin
				phase_d = PH_HEADER;
				pos_d   = '0;
				lab_d   = '0;
				tail_d  = '0;
			end else if (pos_q < POS_MAX) begin
				pos_d = pos_q + POS_W'(1);
			end
		end else if (pos_q >= POS_MAX) begin
			// overlong datagram
			res = '{emit: 1'b1, answer: 1'b0, data: 8'h00, last: 1'b1, abort: 1'b1};
			if (rx_last) begin
				phase_d = PH_HEADER;
				pos_d   = '0;
				lab_d   = '0;
				tail_d  = '0;
			end else begin
				phase_d = PH_DISCARD;
			end
		end else if (phase_q == PH_TAIL && tail_q == 2'd3) begin
			// last type/class byte: echo it, then the answer record
			res    = '{emit: 1'b1, answer: 1'b1, data: rx_byte, last: 1'b0, abort: 1'b0};
			pos_d  = pos_q + POS_W'(1);
			tail_d = '0;
			if (rx_last) begin
				phase_d = PH_HEADER;
				pos_d   = '0;
				lab_d   = '0;
			end else begin
				phase_d = PH_SWALLOW;
			end
		end else if (rx_last) begin
			// datagram ended early
			res     = '{emit: 1'b1, answer: 1'b0, data: 8'h00, last: 1'b1, abort: 1'b1};
			phase_d = PH_HEADER;
			pos_d   = '0;
			lab_d   = '0;
			tail_d  = '0;
		end else begin
			res.emit = 1'b1;
			pos_d    = pos_q + POS_W'(1);
			unique case (phase_q)
				PH_HEADER: begin
					if (pos_q == POS_W'(POS_FLAGS_HI))        res.data = RESP_FLAGS[15:8];
					else if (pos_q == POS_W'(POS_FLAGS_LO))   res.data = RESP_FLAGS[7:0];
					else if (pos_q == POS_W'(POS_ANCOUNT_HI)) res.data = ANCOUNT_ONE[15:8];
					else if (pos_q == POS_W'(POS_ANCOUNT_LO)) res.data = ANCOUNT_ONE[7:0];
					if (pos_q == POS_W'(HDR_BYTES - 1)) phase_d = PH_LABLEN;
				end
				PH_LABLEN: begin
					if (rx_byte == 8'd0) begin
						phase_d = PH_TAIL;
						tail_d  = '0;
					end else begin
						lab_d   = rx_byte;
						phase_d = PH_LABEL;
					end
				end
				PH_LABEL: begin
					lab_d = lab_dec;
					if (lab_dec == 8'd0) phase_d = PH_LABLEN;
				end
				default: begin
					tail_d = tail_q + 2'd1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			pos_q   <= '0;
			lab_q   <= '0;
			tail_q  <= '0;
		end else if (consume) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			lab_q   <= lab_d;
			tail_q  <= tail_d;
		end
	end

endmodule
`default_nettype wire

/* design/dnsr_tx.sv */
// output register with the answer record burst
`default_nettype none
module dnsr_tx import dnsr_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        load,
	input  wire dnsr_res_t   res,
	input  wire logic [31:0] redirect_ip,
	output logic             free,
	output logic             tx_valid,
	input  wire logic        tx_ready,
	output logic [7:0]       tx_byte,
	output logic             tx_last,
	output logic             tx_abort
);

	logic                 valid_q;
	logic                 burst_q;
	logic [ANS_IDX_W-1:0] idx_q;
	logic [7:0]           byte_q;
	logic                 last_q;
	logic                 abort_q;
	logic                 take;

	assign take     = valid_q && tx_ready;
	assign free     = !valid_q || (tx_ready && !burst_q);
	assign tx_valid = valid_q;
	assign tx_byte  = byte_q;
	assign tx_last  = last_q;
	assign tx_abort = abort_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			burst_q <= 1'b0;
			idx_q   <= '0;
		end else if (take && burst_q) begin
			idx_q <= idx_q + ANS_IDX_W'(1);
			if (idx_q == ANS_IDX_W'(ANSWER_BYTES - 1)) burst_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
			burst_q <= res.answer;
			idx_q   <= '0;
		end else if (take) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && burst_q) begin
			byte_q  <= answer_byte(idx_q, redirect_ip);
			last_q  <= (idx_q == ANS_IDX_W'(ANSWER_BYTES - 1));
			abort_q <= 1'b0;
		end else if (load) begin
			byte_q  <= res.data;
			last_q  <= res.last;
			abort_q <= res.abort;
		end
	end

endmodule
`default_nettype wire

/* design/dns_redirect_responder_top.sv */
// top level of the captive portal dns redirect responder
// path: a request byte is held in the input register, and its result then in the output register
// throughput: one byte per cycle while m_tready is high; the last type/class byte is
//   followed by 16 answer bytes from the output register, during which the next byte that
//   gives a result waits and input stalls; swallowed bytes still pass
// reset: arst_n clears the parser to the header phase, empties the input and output
//   registers and sets redirect_ip to zero
`default_nettype none
module dns_redirect_responder_top import dnsr_pkg::*; #(
	parameter int MAX_PACKET_BYTES = MAX_PACKET_BYTES_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// query byte stream
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [7:0]            s_tdata,   // [7:0] rx_byte
	input  wire logic                  s_tlast,   // rx_last
	// response byte stream
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [7:0]                 m_tdata,   // [7:0] tx_byte
	output logic                       m_tlast,   // tx_last
	output logic [0:0]                 m_tuser,   // [0] tx_abort
	// configuration
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [31:0]           pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);

	logic [31:0] redirect_ip_q;
	logic        in_valid_s1;
	logic [7:0]  in_byte_s1;
	logic        in_last_s1;
	logic        consume;
	logic        tx_free;
	logic        tx_abort;
	dnsr_res_t   res;

	// apb register file: one register, no wait states
	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_REDIRECT_IP) ? redirect_ip_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			redirect_ip_q <= 32'd0;
		end else if (psel && penable && pwrite && pready && paddr == ADDR_REDIRECT_IP) begin
			redirect_ip_q <= pwdata;
		end
	end

	// input register; a byte leaves it when the parser can hand on its result,
	// or at once when it gives no result (swallowed or discarded bytes)
	assign consume  = in_valid_s1 && (!res.emit || tx_free);
	assign s_tready = !in_valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			in_byte_s1 <= s_tdata;
			in_last_s1 <= s_tlast;
		end
	end

	// parse state and per-byte decision
	dnsr_parser #(
		.MAX_PACKET_BYTES(MAX_PACKET_BYTES)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx_byte (in_byte_s1),
		.rx_last (in_last_s1),
		.consume (consume),
		.res     (res)
	);

	// output register, also plays out the answer record
	dnsr_tx u_tx (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (consume && res.emit),
		.res         (res),
		.redirect_ip (redirect_ip_q),
		.free        (tx_free),
		.tx_valid    (m_tvalid),
		.tx_ready    (m_tready),
		.tx_byte     (m_tdata),
		.tx_last     (m_tlast),
		.tx_abort    (tx_abort)
	);

	assign m_tuser = tx_abort;

endmodule
`default_nettype wire

/* design/dnsr_checker.sv */
// port-level checks of the responder, bound to the top level
`default_nettype none
module dnsr_port_checks import dnsr_pkg::*; (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  m_tvalid,
	input wire logic                  m_tready,
	input wire logic [7:0]            m_tdata,
	input wire logic                  m_tlast,
	input wire logic [0:0]            m_tuser,
	input wire logic                  psel,
	input wire logic                  penable,
	input wire logic                  pwrite,
	input wire logic [APB_ADDR_W-1:0] paddr,
	input wire logic [31:0]           pwdata,
	input wire logic [31:0]           prdata
);

	// no response while held in reset
	a_idle_in_reset: assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("response valid during reset");

	// an abort is always a lone final zero byte
	a_abort_form: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tlast && m_tdata == 8'h00)
		else $error("abort result not final or not zero");

	// a stalled response holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser))
		else $error("stalled response changed");

	// a written address reads back
	a_readback: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && paddr == ADDR_REDIRECT_IP
		|=> paddr != ADDR_REDIRECT_IP || prdata == $past(pwdata))
		else $error("redirect_ip read-back mismatch");

endmodule

bind dns_redirect_responder_top dnsr_port_checks u_dnsr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser),
	.psel     (psel),
	.penable  (penable),
	.pwrite   (pwrite),
	.paddr    (paddr),
	.pwdata   (pwdata),
	.prdata   (prdata)
);
`default_nettype wire
